@@ design/b64enc_pkg.sv @@
// ----------------------------------------------------------------------------
// b64enc_pkg
// Shared types, constants and the symbol-to-ASCII mapping of the base64
// stream encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // characters per queued entry
    localparam int MAX_CHARS = 4;

    // ASCII codes used by the alphabet mapping
    localparam logic [6:0] PAD_CHAR   = 7'h3D;
    localparam logic [6:0] ASCII_UPPER = 7'h41;
    localparam logic [6:0] ASCII_LOWER = 7'h61;
    localparam logic [6:0] ASCII_DIGIT = 7'h30;
    localparam logic [6:0] ASCII_PLUS  = 7'h2B;
    localparam logic [6:0] ASCII_SLASH = 7'h2F;

    // position of the next byte in its three-byte group
    typedef enum logic [1:0] {
        PHASE_0 = 2'd0,
        PHASE_1 = 2'd1,
        PHASE_2 = 2'd2
    } phase_t;

    typedef logic [6:0] char_t;

    // one classified byte: up to four characters, index of the last one
    typedef struct packed {
        char_t [MAX_CHARS-1:0] chars;
        logic  [1:0]           last_idx;
        logic                  is_final;
    } entry_t;

    // front to queue
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_push_t;

    // queue head toward the back
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_head_t;

    // standard base64 alphabet
    function automatic char_t sym_to_ascii(input logic [5:0] sym);
        char_t code;
        case (sym) inside
            [6'd0:6'd25]:  code = ASCII_UPPER + 7'(sym);
            [6'd26:6'd51]: code = ASCII_LOWER + 7'(sym - 6'd26);
            [6'd52:6'd61]: code = ASCII_DIGIT + 7'(sym - 6'd52);
            6'd62:         code = ASCII_PLUS;
            default:       code = ASCII_SLASH;
        endcase
        return code;
    endfunction

endpackage

@@ design/b64enc_byte_if.sv @@
// ----------------------------------------------------------------------------
// b64enc_byte_if
// Input byte channel: valid/ready handshake with one message byte and the
// end-of-message flag.
// ----------------------------------------------------------------------------
interface b64enc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

@@ design/b64enc_char_if.sv @@
// ----------------------------------------------------------------------------
// b64enc_char_if
// Output character channel: valid/ready handshake with one ASCII character
// and the end-of-message flag.
// ----------------------------------------------------------------------------
interface b64enc_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       final_char;

    modport source (output valid, output char_code, output final_char, input ready);
    modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

@@ design/b64enc_front.sv @@
// ----------------------------------------------------------------------------
// b64enc_front
// Accepts bytes, tracks group phase and leftover bits, and turns each byte
// into one queue entry holding all characters that it produces.
// ----------------------------------------------------------------------------
module b64enc_front (
    input  logic                clk,
    input  logic                rst_n,
    b64enc_byte_if.sink         byte_stream,
    input  logic                q_not_full,
    output b64enc_pkg::q_push_t push
);
    import b64enc_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [3:0] carry_reg, carry_next;
    logic       accept;
    logic [7:0] b;
    logic [5:0] sym0, sym1, flush_sym;
    entry_t     entry;

    assign byte_stream.ready = q_not_full;
    assign accept = byte_stream.valid && q_not_full;
    assign b = byte_stream.data_byte;

    // next phase and leftover bits
    always_comb
    begin
        phase_next = phase_reg;
        carry_next = carry_reg;
        if (accept)
        begin
            case (phase_reg)
                PHASE_1:
                begin
                    phase_next = PHASE_2;
                    carry_next = b[3:0];
                end
                PHASE_2:
                begin
                    phase_next = PHASE_0;
                    carry_next = 4'd0;
                end
                default:
                begin
                    phase_next = PHASE_1;
                    carry_next = {2'b00, b[1:0]};
                end
            endcase
            // end of message restarts the group
            if (byte_stream.final_byte)
            begin
                phase_next = PHASE_0;
                carry_next = 4'd0;
            end
        end
    end

    // characters of this byte
    always_comb
    begin
        case (phase_reg)
            PHASE_1:
            begin
                sym0      = {carry_reg[1:0], b[7:4]};
                flush_sym = {b[3:0], 2'b00};
            end
            PHASE_2:
            begin
                sym0      = {carry_reg, b[7:6]};
                flush_sym = {b[3:0], 2'b00};
            end
            default:
            begin
                sym0      = b[7:2];
                flush_sym = {b[1:0], 4'b0000};
            end
        endcase
        sym1 = (phase_reg == PHASE_2) ? b[5:0] : flush_sym;

        entry.chars[0]  = sym_to_ascii(sym0);
        entry.chars[1]  = sym_to_ascii(sym1);
        entry.chars[2]  = PAD_CHAR;
        entry.chars[3]  = PAD_CHAR;
        entry.is_final  = byte_stream.final_byte;
        if (byte_stream.final_byte)
        begin
            case (phase_reg)
                PHASE_1: entry.last_idx = 2'd2;
                PHASE_2: entry.last_idx = 2'd1;
                default: entry.last_idx = 2'd3;
            endcase
        end
        else
        begin
            entry.last_idx = (phase_reg == PHASE_2) ? 2'd1 : 2'd0;
        end
    end

    assign push.valid = accept;
    assign push.entry = entry;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_0;
            carry_reg <= 4'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

@@ design/b64enc_queue.sv @@
// ----------------------------------------------------------------------------
// b64enc_queue
// Short first-in first-out queue of classified entries between the front
// and the back.
// ----------------------------------------------------------------------------
module b64enc_queue #(
    parameter int DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  b64enc_pkg::q_push_t push,
    input  logic                pop,
    output logic                not_full,
    output b64enc_pkg::q_head_t head
);
    import b64enc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    entry_t           mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign not_full   = (count_reg != FULL_CNT);
    assign head.valid = (count_reg != '0);
    assign head.entry = mem[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push.valid && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

    // queue bookkeeping checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> not_full || pop)
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count out of range");

endmodule

@@ design/b64enc_back.sv @@
// ----------------------------------------------------------------------------
// b64enc_back
// Walks the characters of the queue head one per cycle into a registered
// output stage while that stage is empty or being taken, and pops the entry as its last character is loaded.
// ----------------------------------------------------------------------------
module b64enc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  b64enc_pkg::q_head_t head,
    output logic                pop,
    b64enc_char_if.source       char_stream
);
    import b64enc_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    char_t      code_reg, code_next;
    logic       final_reg, final_next;
    logic       load;
    logic       at_last;

    assign load    = !out_valid_reg || char_stream.ready;
    assign at_last = (idx_reg == head.entry.last_idx);
    assign pop     = load && head.valid && at_last;

    // character index and output stage
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        code_next      = code_reg;
        final_next     = final_reg;
        if (load)
        begin
            out_valid_next = head.valid;
            if (head.valid)
            begin
                code_next  = head.entry.chars[idx_reg];
                final_next = head.entry.is_final && at_last;
                idx_next   = at_last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        final_reg <= final_next;
    end

    assign char_stream.valid      = out_valid_reg;
    assign char_stream.char_code  = code_reg;
    assign char_stream.final_char = final_reg;

    // walk and pop consistency
    a_idx_in_entry: assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> idx_reg <= head.entry.last_idx)
        else $error("character index beyond entry");

    a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> idx_reg == 2'd0)
        else $error("index not cleared after pop");

    a_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        !head.valid |-> idx_reg == 2'd0)
        else $error("index moved without queued entry");

endmodule

@@ design/base64_stream_encoder.sv @@
// Path: an accepted byte is written into the entry queue, and its characters are
// then loaded into the output register one per cycle while the character port
// takes them; a byte yields one to four characters: one mid-stream, two for a
// byte that closes a group, and up to four for a final byte.
// The entry queue lets bytes be accepted while earlier characters still wait to drain.
// Reset: rst_n clears the group phase, leftover bits, queue and output valid at once.
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Standard-alphabet base64 encoder for a byte stream with end-of-message
// flag; front classifier, entry queue and character emitter.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    b64enc_byte_if.sink   byte_stream,
    b64enc_char_if.source char_stream
);
    import b64enc_pkg::*;

    q_push_t push;
    q_head_t head;
    logic    q_not_full;
    logic    pop;

    // classify incoming bytes
    b64enc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .q_not_full  (q_not_full),
        .push        (push)
    );

    // entry queue
    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (pop),
        .not_full (q_not_full),
        .head     (head)
    );

    // emit characters
    b64enc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .char_stream (char_stream)
    );

endmodule

@@ tb/base64_stream_encoder_tb.sv @@
// ----------------------------------------------------------------------------
// base64_stream_encoder_tb
// Self-checking bench for the base64 stream encoder. Bytes go in on the byte
// channel, and each accepted transaction is encoded by a behavioral encoder
// in the bench into the characters it should yield. Characters leaving the
// block are compared in order against that expectation or a directed row's
// typed characters. A directed table comes first, then random messages with
// idle gaps on both channels, a long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
module base64_stream_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import b64enc_pkg::*;

    localparam int WATCHDOG_CYCLES  = 4000;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES     = 10;
    localparam int MAX_PRINTED      = 20;

    // standard alphabet, symbol 0 in the top byte
    localparam logic [511:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // one expected character
    typedef struct packed {
        char_t code;
        logic  last;
    } char_item_t;

    // directed row: typed characters right-justified, zero means use the encoder
    typedef struct packed {
        logic [7:0]  data;
        logic        fin;
        logic [31:0] typed;
    } dir_row_t;

    logic clk;
    logic rst_n;

    b64enc_byte_if byte_stream ();
    b64enc_char_if char_stream ();

    base64_stream_encoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .char_stream (char_stream)
    );

    char_item_t expected_chars[$];
    char_item_t byte_chars[$];
    phase_t     enc_phase = PHASE_0;
    logic [3:0] enc_carry = 4'h0;
    int         mismatch_count = 0;
    int         char_index = 0;
    int         idle_cycles = 0;
    bit         sink_idles = 1'b1;
    bit         hold_request = 1'b0;

    dir_row_t directed_rows [23] = '{
        '{8'h00, 1'b1, "AA=="},
        '{8'hFF, 1'b1, "/w=="},
        '{8'h4D, 1'b0, "T"},
        '{8'h61, 1'b0, "W"},
        '{8'h6E, 1'b1, "Fu"},
        '{8'hFF, 1'b0, "/"},
        '{8'hFF, 1'b0, "/"},
        '{8'hFF, 1'b1, "//"},
        '{8'h00, 1'b0, "A"},
        '{8'h00, 1'b1, "AA="},
        '{8'hFF, 1'b0, "/"},
        '{8'hFF, 1'b1, "/8="},
        '{8'h80, 1'b0, 32'h0},
        '{8'h01, 1'b0, 32'h0},
        '{8'h7F, 1'b0, 32'h0},
        '{8'hAA, 1'b0, 32'h0},
        '{8'h55, 1'b1, 32'h0},
        '{8'hFE, 1'b0, 32'h0},
        '{8'h01, 1'b1, 32'h0},
        '{8'h3F, 1'b0, 32'h0},
        '{8'hC0, 1'b0, 32'h0},
        '{8'h0F, 1'b0, 32'h0},
        '{8'hF0, 1'b1, 32'h0}
    };

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return $urandom_range(8, 30);
        else if (r < 6)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic char_t alphabet_char(input logic [5:0] six);
        return B64_ALPHABET[(63 - int'(six)) * 8 +: 7];
    endfunction

    // append one character to the current byte's list
    task automatic add_byte_char(input char_t code);
        byte_chars.insert(byte_chars.size(), char_item_t'{code, 1'b0});
    endtask

    // append one character to the expected stream
    task automatic add_expected(input char_item_t item);
        expected_chars.insert(expected_chars.size(), item);
    endtask

    task automatic emit_symbol(input logic [5:0] six);
        add_byte_char(alphabet_char(six));
    endtask

    // encodes one byte into byte_chars and advances the group state
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        byte_chars.delete();
        case (enc_phase)
            PHASE_1:
            begin
                emit_symbol({enc_carry[1:0], b[7:4]});
                enc_carry = b[3:0];
                enc_phase = PHASE_2;
            end
            PHASE_2:
            begin
                emit_symbol({enc_carry, b[7:6]});
                emit_symbol(b[5:0]);
                enc_carry = 4'h0;
                enc_phase = PHASE_0;
            end
            default:
            begin
                emit_symbol(b[7:2]);
                enc_carry = {2'b00, b[1:0]};
                enc_phase = PHASE_1;
            end
        endcase
        // flush leftover bits and pad to a four-character boundary
        if (fin)
        begin
            case (enc_phase)
                PHASE_1:
                begin
                    emit_symbol({enc_carry[1:0], 4'h0});
                    add_byte_char(PAD_CHAR);
                    add_byte_char(PAD_CHAR);
                end
                PHASE_2:
                begin
                    emit_symbol({enc_carry, 2'b00});
                    add_byte_char(PAD_CHAR);
                end
                default:
                begin
                end
            endcase
            byte_chars[byte_chars.size() - 1].last = 1'b1;
            enc_carry = 4'h0;
            enc_phase = PHASE_0;
        end
    endtask

    // offer one byte and return at the edge where it is taken
    task automatic send_byte(input logic [7:0] b, input logic fin, input int gap);
        if (gap > 0)
        begin
            byte_stream.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_stream.valid      <= 1'b1;
        byte_stream.data_byte  <= b;
        byte_stream.final_byte <= fin;
        @(posedge clk);
        while (!byte_stream.ready)
            @(posedge clk);
    endtask

    // random messages until at least n_items bytes have gone
    task automatic send_messages(input int n_items, input bit src_idles);
        int         sent;
        int         msg_len;
        logic [7:0] b;
        sent = 0;
        while (sent < n_items)
        begin
            msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                  : $urandom_range(1, 6);
            for (int k = 0; k < msg_len; k++)
            begin
                case ($urandom_range(0, 15))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom);
                endcase
                send_byte(b, k == msg_len - 1, src_idles ? pick_gap() : 0);
                encode_byte(b, k == msg_len - 1);
                foreach (byte_chars[j])
                    add_expected(byte_chars[j]);
                sent++;
            end
        end
    endtask

    // stop offering until every expected character has come out
    task automatic pause_until_drained();
        byte_stream.valid <= 1'b0;
        wait (expected_chars.size() == 0);
        @(posedge clk);
    endtask

    // byte source and run control
    initial
    begin : byte_source
        logic [7:0] c;
        rst_n                  = 1'b0;
        byte_stream.valid      = 1'b0;
        byte_stream.data_byte  = 8'h00;
        byte_stream.final_byte = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].data, directed_rows[i].fin, pick_gap());
            encode_byte(directed_rows[i].data, directed_rows[i].fin);
            if (directed_rows[i].typed == 32'h0)
            begin
                foreach (byte_chars[j])
                    add_expected(byte_chars[j]);
            end
            else
            begin
                for (int k = 3; k >= 0; k--)
                begin
                    c = directed_rows[i].typed[8 * k +: 8];
                    if (c != 8'h00)
                        add_expected(char_item_t'{c[6:0], 1'b0});
                end
                if (directed_rows[i].fin)
                    expected_chars[expected_chars.size() - 1].last = 1'b1;
            end
        end
        pause_until_drained();

        // random messages, idling on both sides
        send_messages(60, 1'b1);

        // stretch without idling
        sink_idles = 1'b0;
        send_messages(35, 1'b0);
        pause_until_drained();

        // receiver holds off while bytes keep coming
        hold_request = 1'b1;
        send_messages(35, 1'b0);
        pause_until_drained();

        sink_idles = 1'b1;
        send_messages(75, 1'b1);

        // drain and settle
        byte_stream.valid <= 1'b0;
        wait (expected_chars.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // character sink with random back-pressure
    initial
    begin : char_sink
        int hi_cycles;
        int lo_cycles;
        char_stream.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                char_stream.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            hi_cycles = $urandom_range(1, 8);
            lo_cycles = sink_idles ? pick_gap() : 0;
            char_stream.ready <= 1'b1;
            repeat (hi_cycles) @(posedge clk);
            if (lo_cycles > 0)
            begin
                char_stream.ready <= 1'b0;
                repeat (lo_cycles) @(posedge clk);
            end
        end
    end

    // compare each character transaction with the oldest expectation
    always @(posedge clk)
    begin : char_check
        char_item_t exp_item;
        if (rst_n && char_stream.valid && char_stream.ready)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected char 0x%02h final %0b",
                                          char_stream.char_code, char_stream.final_char));
            end
            else
            begin
                exp_item = expected_chars.pop_front();
                if (char_stream.char_code !== exp_item.code)
                    report_mismatch($sformatf("char %0d code: expected 0x%02h got 0x%02h",
                                              char_index, exp_item.code,
                                              char_stream.char_code));
                if (char_stream.final_char !== exp_item.last)
                    report_mismatch($sformatf("char %0d final: expected %0b got %0b",
                                              char_index, exp_item.last,
                                              char_stream.final_char));
            end
            char_index++;
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((byte_stream.valid && byte_stream.ready) ||
            (char_stream.valid && char_stream.ready))
        begin
            idle_cycles <= 0;
        end
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("timeout: no transaction for %0d cycles", idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
